[rtl/core/humidity_temp_frame_decoder_top_macros.svh]
// Assertion macros for the frame decoder.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
`define HTFD_CHECK(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame decoder check failed");
`define HTFD_CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame decoder sequence check failed");
`else
`define HTFD_CHECK(lbl, clk, rst, ante, cons)
`define HTFD_CHECK_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/htfd_pkg.sv]
package htfd_pkg;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [15:0] HALF_SCALE  = 16'd32767;
  localparam logic [15:0] FULL_SCALE  = 16'd65535;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [13:0] HUM_TOP     = HUM_MAX + HUM_OFFSET;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/humidity_temp_frame_decoder_top.sv]
// Humidity/temperature frame decoder.
// Input channel (in_valid/in_stall): one word carries a sensor response,
// temp_word with temp_check and hum_word with hum_check. Both CRC-8 checks
// (poly 0x31, init 0xFF, high byte first) must pass.
// Output channel (out_valid/out_stall): status, temperature_centi
// (hundredths of a degree C) and humidity_centi (hundredths of a percent RH,
// clamped to 0..10000). On a CRC mismatch status is 1 and both values are 0.
// One word is accepted per cycle while the receiver does not stall; the
// pipeline has four stages (multiply and first CRC byte, round add and second
// CRC byte, quotient correction, offset and clamp).
// Each stage holds its word only while the stage after it is full and
// blocked; empty stages keep filling, so up to four words sit in flight
// while the receiver stalls, and in_stall rises once the pipeline is full.
// Reset (rst, synchronous) empties the pipeline; no results are pending.
`include "humidity_temp_frame_decoder_top_macros.svh"

module humidity_temp_frame_decoder_top
  import htfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        temp_word,
  input  logic [7:0]         temp_check,
  input  logic [15:0]        hum_word,
  input  logic [7:0]         hum_check,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);

  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready4;

  logic [30:0] tprod1;
  logic [29:0] hprod1;
  logic [7:0]  tcrc1, hcrc1, tlo1, hlo1, tchk1, hchk1;

  logic        err2;
  logic [14:0] ta2;
  logic [15:0] tb2;
  logic [13:0] ha2;
  logic [15:0] hb2;

  logic        err3;
  logic [14:0] tq3;
  logic [13:0] hq3;

  logic [30:0] tx;
  logic [29:0] hx;
  logic [16:0] tsum;
  logic [16:0] hsum;
  logic [14:0] tval;
  logic [13:0] hval;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  assign tx   = tprod1 + {15'd0, HALF_SCALE};
  assign hx   = hprod1 + {14'd0, HALF_SCALE};
  assign tsum = {2'd0, ta2} + {1'b0, tb2};
  assign hsum = {3'd0, ha2} + {1'b0, hb2};

  always_comb begin
    tval = tq3 - TEMP_OFFSET;
    if (hq3 < HUM_OFFSET) begin
      hval = '0;
    end else if (hq3 > HUM_TOP) begin
      hval = HUM_MAX;
    end else begin
      hval = hq3 - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      tprod1 <= 31'(TEMP_SPAN * temp_word);
      hprod1 <= 30'(HUM_SPAN * hum_word);
      tcrc1  <= crc_byte(CRC_INIT, temp_word[15:8]);
      hcrc1  <= crc_byte(CRC_INIT, hum_word[15:8]);
      tlo1   <= temp_word[7:0];
      hlo1   <= hum_word[7:0];
      tchk1  <= temp_check;
      hchk1  <= hum_check;
    end
    if (ready2) begin
      err2 <= (crc_byte(tcrc1, tlo1) != tchk1) || (crc_byte(hcrc1, hlo1) != hchk1);
      ta2  <= tx[30:16];
      tb2  <= tx[15:0];
      ha2  <= hx[29:16];
      hb2  <= hx[15:0];
    end
    if (ready3) begin
      err3 <= err2;
      tq3  <= ta2 + {14'd0, (tsum >= {1'b0, FULL_SCALE})};
      hq3  <= ha2 + {13'd0, (hsum >= {1'b0, FULL_SCALE})};
    end
    if (ready4) begin
      status            <= err3;
      temperature_centi <= err3 ? '0 : $signed(tval);
      humidity_centi    <= err3 ? '0 : hval;
    end
  end

  `HTFD_CHECK(a_err_zero, clk, rst, out_valid && status,
              temperature_centi == 15'sd0 && humidity_centi == 14'd0)
  `HTFD_CHECK(a_hum_range, clk, rst, out_valid, humidity_centi <= HUM_MAX)
  `HTFD_CHECK(a_temp_range, clk, rst, out_valid && !status,
              temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
  `HTFD_CHECK_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, v1)
  `HTFD_CHECK_NEXT(a_blocked_hold, clk, rst, v3 && !ready4, v3 && out_valid)

endmodule

[tb/sv/frame_decode_checker.sv]
package frame_crc_pkg;

  function automatic logic [7:0] word_crc8(input logic [15:0] w);
    logic [7:0] crc;
    logic       fb;
    crc = 8'hFF;
    for (int i = 15; i >= 0; i--) begin
      fb  = crc[7] ^ w[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
    end
    return crc;
  endfunction

endpackage

module frame_decode_checker
  import frame_crc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        temp_word,
  input  logic [7:0]         temp_check,
  input  logic [15:0]        hum_word,
  input  logic [7:0]         hum_check,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               status,
  input  logic signed [14:0] temperature_centi,
  input  logic [13:0]        humidity_centi,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               crc_bad;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } reading_t;

  reading_t readings_q[$];
  int       fail_count = 0;

  assign mismatches = fail_count;

  function automatic reading_t decode_frame(input logic [15:0] t, input logic [7:0] tc,
                                            input logic [15:0] h, input logic [7:0] hc);
    reading_t    r;
    int unsigned tq;
    int unsigned hq;
    int          hval;
    r = '0;
    if (word_crc8(t) != tc || word_crc8(h) != hc) begin
      r.crc_bad = 1'b1;
      return r;
    end
    tq   = (int'(t) * 17500 + 32767) / 65535;
    hq   = (int'(h) * 12500 + 32767) / 65535;
    hval = int'(hq) - 600;
    if (hval < 0) hval = 0;
    if (hval > 10000) hval = 10000;
    r.temp = 15'(int'(tq) - 4500);
    r.hum  = 14'(hval);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        readings_q.push_back(decode_frame(temp_word, temp_check, hum_word, hum_check));
      end
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = readings_q.pop_front();
          if (status !== want.crc_bad) begin
            $error("status: expected %0d, got %0d", want.crc_bad, status);
            fail_count++;
          end
          if (temperature_centi !== want.temp) begin
            $error("temperature_centi: expected %0d, got %0d", want.temp, temperature_centi);
            fail_count++;
          end
          if (humidity_centi !== want.hum) begin
            $error("humidity_centi: expected %0d, got %0d", want.hum, humidity_centi);
            fail_count++;
          end
        end
      end
    end
    outstanding <= readings_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top
  import frame_crc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_FRAMES = 485;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        temp_word = '0;
  logic [7:0]         temp_check = '0;
  logic [15:0]        hum_word = '0;
  logic [7:0]         hum_check = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;

  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  logic steady = 1'b0;

  humidity_temp_frame_decoder_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temp_word        (temp_word),
    .temp_check       (temp_check),
    .hum_word         (hum_word),
    .hum_check        (hum_check),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .temperature_centi(temperature_centi),
    .humidity_centi   (humidity_centi)
  );

  frame_decode_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temp_word        (temp_word),
    .temp_check       (temp_check),
    .hum_word         (hum_word),
    .hum_check        (hum_check),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .temperature_centi(temperature_centi),
    .humidity_centi   (humidity_centi),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("humidity_temp_frame_decoder_top regression: fail");
      $finish;
    end
  end

  task automatic offer_frame(input logic [15:0] t, input logic [7:0] tc,
                             input logic [15:0] h, input logic [7:0] hc);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    temp_word  <= t;
    temp_check <= tc;
    hum_word   <= h;
    hum_check  <= hc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer_good(input logic [15:0] t, input logic [15:0] h);
    offer_frame(t, word_crc8(t), h, word_crc8(h));
  endtask

  initial begin
    logic [15:0] t;
    logic [15:0] h;
    logic [7:0]  tc;
    logic [7:0]  hc;
    int          kind;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_good(16'h0000, 16'h0000);
    offer_good(16'hFFFF, 16'hFFFF);
    offer_good(16'h0000, 16'hFFFF);
    offer_good(16'hFFFF, 16'h0000);
    offer_good(16'h6666, 16'd3145);
    offer_good(16'h8000, 16'd3149);
    offer_good(16'h1234, 16'd3150);
    offer_good(16'h5555, 16'd55560);
    offer_good(16'hAAAA, 16'd55574);
    offer_good(16'hA5A5, 16'd55580);
    offer_frame(16'h4000, word_crc8(16'h4000) ^ 8'h01, 16'h8000, word_crc8(16'h8000));
    offer_frame(16'h4000, word_crc8(16'h4000), 16'h8000, word_crc8(16'h8000) ^ 8'h80);
    offer_frame(16'hBEEF, word_crc8(16'hBEEF) ^ 8'hFF, 16'h0F0F, word_crc8(16'h0F0F) ^ 8'h5A);
    offer_frame(16'hFFFF, 8'h00, 16'hFFFF, 8'hFF);
    offer_frame(16'h0000, 8'hFF, 16'h0000, 8'h00);

    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      steady <= (i >= 150 && i < 270);
      t    = 16'($urandom);
      h    = 16'($urandom);
      tc   = word_crc8(t);
      hc   = word_crc8(h);
      kind = $urandom_range(0, 99);
      if (kind >= 70 && kind < 78) begin
        tc ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 78 && kind < 86) begin
        hc ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 86 && kind < 93) begin
        t ^= 16'(1 << $urandom_range(0, 15));
      end else if (kind >= 93) begin
        tc = 8'($urandom);
        hc = 8'($urandom);
      end
      offer_frame(t, tc, h, hc);
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("humidity_temp_frame_decoder_top regression: pass");
    end else begin
      $display("humidity_temp_frame_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/htfd_pkg.sv
rtl/core/humidity_temp_frame_decoder_top.sv
tb/sv/frame_decode_checker.sv
tb/sv/tb_top.sv
